[design/nmc_pkg.sv]
package nmc_pkg;

  // Configuration port
  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  // Request kinds on the input stream
  localparam logic REQ_CELL  = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // Frame geometry
  localparam int ROW_W = 10;
  localparam logic [CFG_W-1:0] HEIGHT_MAX = 11'd1024;

  // Window: two registered columns (left, center); the right one comes from the line store
  localparam int WIN = 2;

  // Result queue
  localparam int OQ_DEPTH = 8;
  localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
  localparam int OQ_LVL_W = $clog2(OQ_DEPTH + 1);

  // One window column, top in the lowest bit
  typedef struct packed {
    logic bot;
    logic mid;
    logic top;
  } col_t;

  // One result item
  typedef struct packed {
    logic       frame_end;
    logic       row_end;
    logic [3:0] count;
    logic       marked;
  } res_t;

  // Results written to the queue in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    res_t       d0;
    res_t       d1;
  } push_t;

  function automatic logic [1:0] pc3(input col_t c);
    pc3 = {1'b0, c.top} + {1'b0, c.mid} + {1'b0, c.bot};
  endfunction

endpackage

[design/nmc_ram.sv]
module nmc_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Read returns the old word when the same address is written
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/nmc_col_cell.sv]
module nmc_col_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  logic          clear_i,
  input  nmc_pkg::col_t col_i,
  output nmc_pkg::col_t col_o
);
  import nmc_pkg::*;

  col_t col_q;
  col_t col_d;

  // Take the neighbor's column on a shift, or zero when the row restarts
  always_comb begin
    col_d = col_q;
    if (shift_i) begin
      col_d = clear_i ? col_t'('0) : col_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
    end else begin
      col_q <= col_d;
    end
  end

  assign col_o = col_q;

endmodule

[design/nmc_out_fifo.sv]
module nmc_out_fifo (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  nmc_pkg::push_t                  push_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output nmc_pkg::res_t                   out_data_o,
  output logic [nmc_pkg::OQ_LVL_W-1:0]    level_o
);
  import nmc_pkg::*;

  res_t                mem_q [OQ_DEPTH];
  logic [OQ_PTR_W-1:0] wr_q, wr_d, wr_nxt;
  logic [OQ_PTR_W-1:0] rd_q, rd_d;
  logic [OQ_LVL_W-1:0] cnt_q, cnt_d;
  logic                pop;

  assign wr_nxt = wr_q + OQ_PTR_W'(1);
  assign pop    = out_valid_o && out_ready_i;

  // Store up to two results in order
  always_ff @(posedge clk_i) begin
    if (push_i.cnt != 2'd0) begin
      mem_q[wr_q] <= push_i.d0;
    end
    if (push_i.cnt == 2'd2) begin
      mem_q[wr_nxt] <= push_i.d1;
    end
  end

  // Advance pointers and fill level
  always_comb begin
    wr_d  = wr_q + OQ_PTR_W'(push_i.cnt);
    rd_d  = pop ? rd_q + OQ_PTR_W'(1) : rd_q;
    cnt_d = cnt_q + OQ_LVL_W'(push_i.cnt) - OQ_LVL_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_q];
  assign level_o     = cnt_q;

endmodule

[design/neighbour_mark_count_3x3.sv]
// Order: a result passes through the s1_q stage and the result queue after the transaction
// that releases it (the cell one row below and one column right, or a flush for the last
// row); a second result from the same transaction enters the queue with it and follows it.
// Throughput: 1 transaction per cycle while the result queue has room; input pauses after
// a frame's last cell while column 0 of the line store is read to seed the flush window.
// Reset: counters, window cells and queue clear, both registers read 1; the line store
// is not cleared and needs no clearing pass.
module neighbour_mark_count_3x3 #(
  parameter int MAX_WIDTH = 1024
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [7:0]                      s_axis_tdata,  // [0] cell_marked
  input  logic                            s_axis_tuser,  // [0] req_type
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [7:0]                      m_axis_tdata,  // [0] out_marked, [4:1] neighbour_count
  output logic                            m_axis_tlast,  // row_end
  output logic                            m_axis_tuser,  // [0] frame_end
  input  logic                            cfg_we_i,
  input  logic [nmc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [nmc_pkg::CFG_W-1:0]       cfg_wdata_i
);
  import nmc_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef struct packed {
    logic             clear;
    logic             top_en;
    logic             mid_en;
    logic             bot;
    logic             zero_col;
    logic             wr_en;
    logic             emit_a;
    logic             emit_b;
    logic             a_last;
    logic             fwd_hit;
    logic [1:0]       fwd_data;
    logic [COL_W-1:0] addr;
  } op_t;

  // Configuration registers
  logic [CFG_W-1:0] frame_width_q, frame_height_q;
  logic [CFG_W-1:0] w_eff, h_eff, wlast, hlast;
  logic [COL_W-1:0] wlast_col;
  logic             h2;

  // Input side position
  logic [COL_W-1:0] in_col_q, in_col_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic [COL_W-1:0] fl_col_q, fl_col_d;
  logic             flush_phase_q, flush_phase_d;
  logic             prime_q, prime_d;

  // Pipeline
  op_t              s0_op, s1_q;
  logic             s0_valid, s1_valid_q;
  logic             in_acc, cell_go, flush_go;
  logic             ic_last, fl_last;

  // Line store and window
  logic [1:0]       ram_rdata, raw, ram_wdata;
  logic             ram_we;
  col_t             new_col, left_col, ctr_col;
  col_t             chain_in [WIN];
  col_t             chain_q  [WIN];

  // Results
  res_t             res_a, res_b, out_res;
  push_t            push;
  logic [OQ_LVL_W-1:0] level;
  logic [3:0]       cnt_a, cnt_b;

  // Write configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= 11'd1;
      frame_height_q <= 11'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata_i;
        REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Clamp geometry to the supported range
  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = 11'd1;
    end else if (32'(frame_width_q) > MAX_WIDTH) begin
      w_eff = 11'(MAX_WIDTH);
    end else begin
      w_eff = frame_width_q;
    end
    if (frame_height_q == '0) begin
      h_eff = 11'd1;
    end else if (frame_height_q > HEIGHT_MAX) begin
      h_eff = HEIGHT_MAX;
    end else begin
      h_eff = frame_height_q;
    end
  end

  assign wlast     = w_eff - 11'd1;
  assign hlast     = h_eff - 11'd1;
  assign wlast_col = COL_W'(wlast);
  assign h2        = (hlast != '0);

  // Accept while not seeding the flush window and the queue has room for what is in flight plus two results
  assign s_axis_tready = !prime_q &&
                         (({1'b0, level} + {{(OQ_LVL_W - 1){1'b0}}, push.cnt})
                          <= (OQ_LVL_W + 1)'(OQ_DEPTH - 2));
  assign in_acc   = s_axis_tvalid && s_axis_tready;
  assign cell_go  = in_acc && (s_axis_tuser == REQ_CELL) && !flush_phase_q;
  assign flush_go = in_acc && (s_axis_tuser == REQ_FLUSH) && flush_phase_q;
  assign ic_last  = (in_col_q == wlast_col);
  assign fl_last  = (fl_col_q == wlast_col);

  // Decode the next operation and advance the position counters
  always_comb begin
    s0_op         = '0;
    s0_valid      = 1'b0;
    in_col_d      = in_col_q;
    in_row_d      = in_row_q;
    fl_col_d      = fl_col_q;
    flush_phase_d = flush_phase_q;
    prime_d       = prime_q;
    if (prime_q) begin
      // seed the flush window with column 0
      s0_valid     = 1'b1;
      s0_op.clear  = 1'b1;
      s0_op.top_en = h2;
      s0_op.mid_en = 1'b1;
      s0_op.addr   = '0;
      prime_d      = 1'b0;
    end else if (cell_go) begin
      s0_valid     = 1'b1;
      s0_op.clear  = (in_col_q == '0);
      s0_op.top_en = (in_row_q > ROW_W'(1));
      s0_op.mid_en = (in_row_q != '0);
      s0_op.bot    = s_axis_tdata[0];
      s0_op.wr_en  = 1'b1;
      s0_op.emit_a = (in_row_q != '0) && (in_col_q != '0);
      s0_op.emit_b = (in_row_q != '0) && ic_last;
      s0_op.addr   = in_col_q;
      if (ic_last) begin
        in_col_d = '0;
        if ({1'b0, in_row_q} == hlast) begin
          in_row_d      = '0;
          flush_phase_d = 1'b1;
          prime_d       = 1'b1;
        end else begin
          in_row_d = in_row_q + ROW_W'(1);
        end
      end else begin
        in_col_d = in_col_q + COL_W'(1);
      end
    end else if (flush_go) begin
      s0_valid       = 1'b1;
      s0_op.top_en   = h2;
      s0_op.mid_en   = 1'b1;
      s0_op.zero_col = fl_last;
      s0_op.emit_a   = 1'b1;
      s0_op.a_last   = fl_last;
      s0_op.addr     = fl_col_q + COL_W'(1);
      if (fl_last) begin
        fl_col_d      = '0;
        flush_phase_d = 1'b0;
      end else begin
        fl_col_d = fl_col_q + COL_W'(1);
      end
    end
    // catch a write to the address read now
    s0_op.fwd_hit  = s1_valid_q && s1_q.wr_en && (s1_q.addr == s0_op.addr);
    s0_op.fwd_data = ram_wdata;
    if (cfg_we_i) begin
      in_col_d      = '0;
      in_row_d      = '0;
      fl_col_d      = '0;
      flush_phase_d = 1'b0;
      prime_d       = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q      <= '0;
      in_row_q      <= '0;
      fl_col_q      <= '0;
      flush_phase_q <= 1'b0;
      prime_q       <= 1'b0;
      s1_valid_q    <= 1'b0;
    end else begin
      in_col_q      <= in_col_d;
      in_row_q      <= in_row_d;
      fl_col_q      <= fl_col_d;
      flush_phase_q <= flush_phase_d;
      prime_q       <= prime_d;
      s1_valid_q    <= s0_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s0_valid) begin
      s1_q <= s0_op;
    end
  end

  // Line store: bit 0 upper line, bit 1 middle line
  nmc_ram #(
    .WIDTH (2),
    .DEPTH (MAX_WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (s1_q.addr),
    .wdata_i (ram_wdata),
    .re_i    (s0_valid && !s0_op.zero_col),
    .raddr_i (s0_op.addr),
    .rdata_o (ram_rdata)
  );

  // Build the incoming column and the line store update
  always_comb begin
    if (s1_q.zero_col) begin
      raw = 2'b00;
    end else if (s1_q.fwd_hit) begin
      raw = s1_q.fwd_data;
    end else begin
      raw = ram_rdata;
    end
    new_col.top = s1_q.top_en & raw[0];
    new_col.mid = s1_q.mid_en & raw[1];
    new_col.bot = s1_q.bot;
  end

  assign ram_we    = s1_valid_q && s1_q.wr_en;
  assign ram_wdata = {s1_q.bot, raw[1]};

  // Window: chain of column cells, newest column enters the last cell
  for (genvar k = 0; k < WIN; k++) begin : g_cell
    if (k == WIN - 1) begin : g_entry
      assign chain_in[k] = new_col;
    end else begin : g_link
      assign chain_in[k] = chain_q[k+1];
    end
    nmc_col_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (s1_valid_q),
      .clear_i ((k == WIN - 1) ? 1'b0 : s1_q.clear),
      .col_i   (chain_in[k]),
      .col_o   (chain_q[k])
    );
  end

  assign left_col = s1_q.clear ? col_t'('0) : chain_q[WIN-2];
  assign ctr_col  = s1_q.clear ? col_t'('0) : chain_q[WIN-1];

  // Count neighbors: result a centers on the previous column, b on the new one
  always_comb begin
    cnt_a = {2'b00, pc3(left_col)} + {3'b000, ctr_col.top} + {3'b000, ctr_col.bot}
            + {2'b00, pc3(new_col)};
    cnt_b = {2'b00, pc3(ctr_col)} + {3'b000, new_col.top} + {3'b000, new_col.bot};

    res_a.marked    = ctr_col.mid;
    res_a.count     = ctr_col.mid ? 4'd0 : cnt_a;
    res_a.row_end   = s1_q.a_last;
    res_a.frame_end = s1_q.a_last;

    res_b.marked    = new_col.mid;
    res_b.count     = new_col.mid ? 4'd0 : cnt_b;
    res_b.row_end   = 1'b1;
    res_b.frame_end = 1'b0;

    push.cnt = s1_valid_q ? ({1'b0, s1_q.emit_a} + {1'b0, s1_q.emit_b}) : 2'd0;
    push.d0  = s1_q.emit_a ? res_a : res_b;
    push.d1  = res_b;
  end

  nmc_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_res),
    .level_o     (level)
  );

  assign m_axis_tdata = {3'b000, out_res.count, out_res.marked};
  assign m_axis_tlast = out_res.row_end;
  assign m_axis_tuser = out_res.frame_end;

endmodule
